// ===== rtl/core/mmc3mc_pkg.sv =====
package mmc3mc_pkg;

  // Slot counts and index widths.
  localparam int PRG_SLOTS = 4;
  localparam int CHR_SLOTS = 8;
  localparam int PRG_IDX_W = $clog2(PRG_SLOTS);
  localparam int CHR_IDX_W = $clog2(CHR_SLOTS);
  localparam int CHR_HALF  = CHR_SLOTS / 2;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int PRG_W    = 6;
  localparam int PRG_RAW_W = 8;
  localparam int CHR_W    = 9;
  localparam int OUTER_W  = 6;
  localparam int BSEL_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE      = 2'd0;
  localparam logic [OP_W-1:0] OP_PRG_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CHR_LOOKUP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_MAX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_MAX = 1'b1;

  // Bank select codes written at the select register.
  localparam logic [BSEL_W-1:0] BS_CHR_2K_LO = 3'd0;
  localparam logic [BSEL_W-1:0] BS_CHR_2K_HI = 3'd1;
  localparam logic [BSEL_W-1:0] BS_CHR_1K_0  = 3'd2;
  localparam logic [BSEL_W-1:0] BS_CHR_1K_1  = 3'd3;
  localparam logic [BSEL_W-1:0] BS_CHR_1K_2  = 3'd4;
  localparam logic [BSEL_W-1:0] BS_CHR_1K_3  = 3'd5;
  localparam logic [BSEL_W-1:0] BS_PRG_SWAP  = 3'd6;
  localparam logic [BSEL_W-1:0] BS_PRG_MID   = 3'd7;

  // Reset values of the configuration registers and the outer bank.
  localparam logic [PRG_W-1:0]   PRG_MAX_RST = 6'd63;
  localparam logic [CHR_W-1:0]   CHR_MAX_RST = 9'd511;
  localparam logic [OUTER_W-1:0] OUTER_RST   = 6'd1;

  typedef logic [PRG_RAW_W-1:0] prg_raw_arr_t [PRG_SLOTS];
  typedef logic [PRG_W-1:0]     prg_eff_arr_t [PRG_SLOTS];
  typedef logic [CHR_W-1:0]     chr_arr_t     [CHR_SLOTS];

  // Input and result items.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [CHR_W-1:0] bank;
    logic             is_lookup;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  // A bank above the maximum is folded down by masking with the maximum.
  function automatic logic [PRG_W-1:0] limit_prg(input logic [PRG_W-1:0] b,
                                                 input logic [PRG_W-1:0] max);
    return (b > max) ? (b & max) : b;
  endfunction

  function automatic logic [CHR_W-1:0] limit_chr(input logic [CHR_W-1:0] b,
                                                 input logic [CHR_W-1:0] max);
    return (b > max) ? (b & max) : b;
  endfunction

  // PRG slot: outer bank OR the low raw bits (4 bits when outer bit 5 is set).
  function automatic logic [PRG_W-1:0] prg_map(input logic [OUTER_W-1:0]   outer,
                                               input logic [PRG_RAW_W-1:0] raw,
                                               input logic [PRG_W-1:0]     max);
    logic [4:0]       m;
    logic [PRG_W-1:0] b;
    m = outer[5] ? 5'h0F : 5'h1F;
    b = outer | {1'b0, raw[4:0] & m};
    return limit_prg(b, max);
  endfunction

  // CHR slot: outer bank above the three low bits, ORed with the raw bank.
  function automatic logic [CHR_W-1:0] chr_map(input logic [OUTER_W-1:0] outer,
                                               input logic [CHR_W-1:0]   raw,
                                               input logic [CHR_W-1:0]   max);
    return limit_chr({outer, 3'b000} | raw, max);
  endfunction

  // Reset contents of the slot maps, with the outer bank of one applied.
  localparam prg_raw_arr_t PRG_RAW_RST = '{8'd0, 8'd1, 8'd62, 8'd63};
  localparam prg_eff_arr_t PRG_EFF_RST = '{6'd1, 6'd1, 6'd31, 6'd31};
  localparam chr_arr_t CHR_RAW_RST = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7};
  localparam chr_arr_t CHR_EFF_RST = '{9'd8, 9'd9, 9'd10, 9'd11,
                                       9'd12, 9'd13, 9'd14, 9'd15};

endpackage

// ===== rtl/core/mmc3mc_ctrl.sv =====
module mmc3mc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output mmc3mc_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new result when it is empty or draining.
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Capture in idle; apply the item once the output register has room.
  always_comb begin
    state_nxt     = state_r;
    cmd.capture   = 1'b0;
    cmd.execute   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.execute = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A result stays valid until its transfer, unless a new one replaces it.
  always_comb begin
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/mmc3mc_dp.sv =====
module mmc3mc_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mmc3mc_pkg::dp_cmd_t                   cmd,
  input  mmc3mc_pkg::in_item_t                  in_item,
  input  logic                                  cfg_we,
  input  logic [mmc3mc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mmc3mc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output mmc3mc_pkg::out_item_t                 out_item
);

  // Configuration registers.
  logic [mmc3mc_pkg::PRG_W-1:0] prg_max_r;
  logic [mmc3mc_pkg::CHR_W-1:0] chr_max_r;

  // Mapper state.
  logic [mmc3mc_pkg::OUTER_W-1:0] outer_r, outer_nxt;
  logic [mmc3mc_pkg::BSEL_W-1:0]  bank_select_r, bank_select_nxt;
  logic                           prg_mode_r, prg_mode_nxt;
  logic                           chr_mode_r, chr_mode_nxt;
  mmc3mc_pkg::prg_raw_arr_t       prg_raw_r, prg_raw_nxt;
  mmc3mc_pkg::prg_eff_arr_t       prg_eff_r, prg_eff_nxt;
  mmc3mc_pkg::chr_arr_t           chr_raw_r, chr_raw_nxt;
  mmc3mc_pkg::chr_arr_t           chr_eff_r, chr_eff_nxt;

  // Item being worked on and the result register.
  mmc3mc_pkg::in_item_t  item_r;
  mmc3mc_pkg::out_item_t out_r, out_nxt;

  // Address decode of a CPU write.
  logic is_outer_wr, is_select_wr, is_data_wr;

  assign is_outer_wr  = !item_r.address[15] && (item_r.address[14:13] == 2'b11);
  assign is_select_wr = item_r.address[15] && (item_r.address[14:13] == 2'b00)
                        && !item_r.address[0];
  assign is_data_wr   = item_r.address[15] && (item_r.address[14:13] == 2'b00)
                        && item_r.address[0];

  // Next state of the slot maps for a CPU write.
  always_comb begin
    logic [mmc3mc_pkg::OUTER_W-1:0]   new_outer;
    logic [mmc3mc_pkg::PRG_RAW_W-1:0] fixed_raw;
    logic [mmc3mc_pkg::CHR_W-1:0]     v;
    logic [mmc3mc_pkg::CHR_W-1:0]     pair_b;
    logic [mmc3mc_pkg::CHR_IDX_W-1:0] slot;
    logic [mmc3mc_pkg::PRG_IDX_W-1:0] prg_slot;
    logic                             pair_en;
    logic                             single_en;
    logic                             prg_en;

    outer_nxt       = outer_r;
    bank_select_nxt = bank_select_r;
    prg_mode_nxt    = prg_mode_r;
    chr_mode_nxt    = chr_mode_r;
    prg_raw_nxt     = prg_raw_r;
    prg_eff_nxt     = prg_eff_r;
    chr_raw_nxt     = chr_raw_r;
    chr_eff_nxt     = chr_eff_r;

    new_outer = {item_r.data[1:0], 4'b0000};
    fixed_raw = {2'b00, prg_max_r} - 8'd1;
    v         = {1'b0, item_r.data};
    pair_b    = mmc3mc_pkg::limit_chr(({outer_r, 3'b000} | v) & 9'h1FE, chr_max_r);
    slot      = '0;
    prg_slot  = '0;
    pair_en   = 1'b0;
    single_en = 1'b0;
    prg_en    = 1'b0;

    if (cmd.execute && (item_r.op == mmc3mc_pkg::OP_WRITE)) begin
      if (is_outer_wr) begin
        // New outer bank: every slot is remapped from its raw bank.
        if (new_outer != outer_r) begin
          outer_nxt = new_outer;
          for (int i = 0; i < mmc3mc_pkg::PRG_SLOTS; i++) begin
            prg_eff_nxt[i] = mmc3mc_pkg::prg_map(new_outer, prg_raw_r[i], prg_max_r);
          end
          for (int i = 0; i < mmc3mc_pkg::CHR_SLOTS; i++) begin
            chr_eff_nxt[i] = mmc3mc_pkg::chr_map(new_outer, chr_raw_r[i], chr_max_r);
          end
        end
      end else if (is_select_wr) begin
        bank_select_nxt = item_r.data[2:0];
        chr_mode_nxt    = item_r.data[7];
        prg_mode_nxt    = item_r.data[6];
        // CHR mode change swaps the two halves of the pattern table map.
        if (item_r.data[7] != chr_mode_r) begin
          for (int i = 0; i < mmc3mc_pkg::CHR_HALF; i++) begin
            chr_raw_nxt[i] = chr_raw_r[i + mmc3mc_pkg::CHR_HALF];
            chr_raw_nxt[i + mmc3mc_pkg::CHR_HALF] = chr_raw_r[i];
            chr_eff_nxt[i] = chr_eff_r[i + mmc3mc_pkg::CHR_HALF];
            chr_eff_nxt[i + mmc3mc_pkg::CHR_HALF] = chr_eff_r[i];
          end
        end
        // PRG mode change swaps slots 0 and 2 and reloads the newly fixed one.
        if (item_r.data[6] != prg_mode_r) begin
          prg_raw_nxt[0] = prg_raw_r[2];
          prg_raw_nxt[2] = prg_raw_r[0];
          prg_eff_nxt[0] = prg_eff_r[2];
          prg_eff_nxt[2] = prg_eff_r[0];
          if (item_r.data[6]) begin
            prg_raw_nxt[0] = fixed_raw;
            prg_eff_nxt[0] = mmc3mc_pkg::prg_map(outer_r, fixed_raw, prg_max_r);
          end else begin
            prg_raw_nxt[2] = fixed_raw;
            prg_eff_nxt[2] = mmc3mc_pkg::prg_map(outer_r, fixed_raw, prg_max_r);
          end
        end
      end else if (is_data_wr) begin
        // Pick the slot that the current bank select points at.
        case (bank_select_r)
          mmc3mc_pkg::BS_CHR_2K_LO: begin
            pair_en = 1'b1;
            slot    = {chr_mode_r, 2'b00};
          end
          mmc3mc_pkg::BS_CHR_2K_HI: begin
            pair_en = 1'b1;
            slot    = {chr_mode_r, 2'b10};
          end
          mmc3mc_pkg::BS_CHR_1K_0: begin
            single_en = 1'b1;
            slot      = {!chr_mode_r, 2'b00};
          end
          mmc3mc_pkg::BS_CHR_1K_1: begin
            single_en = 1'b1;
            slot      = {!chr_mode_r, 2'b01};
          end
          mmc3mc_pkg::BS_CHR_1K_2: begin
            single_en = 1'b1;
            slot      = {!chr_mode_r, 2'b10};
          end
          mmc3mc_pkg::BS_CHR_1K_3: begin
            single_en = 1'b1;
            slot      = {!chr_mode_r, 2'b11};
          end
          mmc3mc_pkg::BS_PRG_SWAP: begin
            prg_en   = 1'b1;
            prg_slot = {prg_mode_r, 1'b0};
          end
          mmc3mc_pkg::BS_PRG_MID: begin
            prg_en   = 1'b1;
            prg_slot = 2'd1;
          end
          default: begin
            prg_en = 1'b0;
          end
        endcase

        // A 2k CHR bank fills an even slot and the odd slot above it.
        if (pair_en) begin
          chr_raw_nxt[slot]        = v;
          chr_raw_nxt[slot | 3'd1] = v + 9'd1;
          chr_eff_nxt[slot]        = pair_b;
          chr_eff_nxt[slot | 3'd1] = mmc3mc_pkg::limit_chr(pair_b + 9'd1, chr_max_r);
        end
        if (single_en) begin
          chr_raw_nxt[slot] = v;
          chr_eff_nxt[slot] = mmc3mc_pkg::chr_map(outer_r, v, chr_max_r);
        end
        if (prg_en) begin
          prg_raw_nxt[prg_slot] = item_r.data;
          prg_eff_nxt[prg_slot] = mmc3mc_pkg::prg_map(outer_r, item_r.data, prg_max_r);
        end
      end
    end
  end

  // Result of the current item; lookups read the maps before any update.
  always_comb begin
    out_nxt.bank      = '0;
    out_nxt.is_lookup = 1'b0;
    case (item_r.op)
      mmc3mc_pkg::OP_PRG_LOOKUP: begin
        out_nxt.bank      = {3'b000, prg_eff_r[item_r.address[14:13]]};
        out_nxt.is_lookup = 1'b1;
      end
      mmc3mc_pkg::OP_CHR_LOOKUP: begin
        out_nxt.bank      = chr_eff_r[item_r.address[12:10]];
        out_nxt.is_lookup = 1'b1;
      end
      default: begin
        out_nxt.is_lookup = 1'b0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_max_r <= mmc3mc_pkg::PRG_MAX_RST;
      chr_max_r <= mmc3mc_pkg::CHR_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mmc3mc_pkg::CFG_PRG_MAX: prg_max_r <= cfg_wdata[mmc3mc_pkg::PRG_W-1:0];
        mmc3mc_pkg::CFG_CHR_MAX: chr_max_r <= cfg_wdata;
        default: chr_max_r <= chr_max_r;
      endcase
    end
  end

  // Mapper state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_r       <= mmc3mc_pkg::OUTER_RST;
      bank_select_r <= '0;
      prg_mode_r    <= 1'b0;
      chr_mode_r    <= 1'b0;
      prg_raw_r     <= mmc3mc_pkg::PRG_RAW_RST;
      prg_eff_r     <= mmc3mc_pkg::PRG_EFF_RST;
      chr_raw_r     <= mmc3mc_pkg::CHR_RAW_RST;
      chr_eff_r     <= mmc3mc_pkg::CHR_EFF_RST;
    end else begin
      outer_r       <= outer_nxt;
      bank_select_r <= bank_select_nxt;
      prg_mode_r    <= prg_mode_nxt;
      chr_mode_r    <= chr_mode_nxt;
      prg_raw_r     <= prg_raw_nxt;
      prg_eff_r     <= prg_eff_nxt;
      chr_raw_r     <= chr_raw_nxt;
      chr_eff_r     <= chr_eff_nxt;
    end
  end

  // Item and result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.execute) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

// ===== rtl/core/multicart_mmc3_bank_mapper_core.sv =====
// Bank switching for an MMC3-style multicart: CPU writes set the outer bank
// (0x6000-0x7FFF), the bank select and modes (0x8000) and bank data (0x8001);
// PRG and CHR lookups return the effective bank of a slot, with the outer bank
// applied and banks above the configured maximum masked down. Every transfer
// in produces exactly one transfer out (bank and is_lookup are zero for writes
// and unused ops). An item is first captured into the input register; then the
// slot maps are updated and the output register is loaded, so the block takes
// no new item until it is through with the last one. The input side is stalled
// from the capture until the update, and the update waits while a finished
// result is still stalled in the output register. The maximum-bank registers may
// be written only while the block is idle; they affect only later remaps and
// bank writes.
module multicart_mmc3_bank_mapper_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mmc3mc_pkg::in_item_t              in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mmc3mc_pkg::out_item_t             out_item,
  input  logic                              cfg_we,
  input  logic [mmc3mc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmc3mc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mmc3mc_pkg::dp_cmd_t cmd;

  // Sequencing of capture and update.
  mmc3mc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Slot maps, configuration and result register.
  mmc3mc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

endmodule

// ===== test/multicart_mmc3_bank_mapper_core_test.sv =====
`timescale 1ns / 1ps

module multicart_mmc3_bank_mapper_core_test;
  import mmc3mc_pkg::*;

  // Codes and addresses that the package does not name.
  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [ADDR_W-1:0] OUTER_BASE  = 16'h6000;
  localparam logic [ADDR_W-1:0] SELECT_ADDR = 16'h8000;
  localparam logic [ADDR_W-1:0] DATA_ADDR   = 16'h8001;
  localparam logic [ADDR_W-1:0] DECODE_MASK = 16'hE001;

  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int LONG_HOLD       = 60;

  // Tracks the slot maps of the cartridge and the bank answers still owed.
  class bank_map_scoreboard;
    logic [PRG_W-1:0]     prg_limit;
    logic [CHR_W-1:0]     chr_limit;
    logic [OUTER_W-1:0]   outer;
    logic [BSEL_W-1:0]    select;
    logic                 prg_swap;
    logic                 chr_swap;
    logic [PRG_RAW_W-1:0] prg_raw [PRG_SLOTS];
    logic [PRG_W-1:0]     prg_eff [PRG_SLOTS];
    logic [CHR_W-1:0]     chr_raw [CHR_SLOTS];
    logic [CHR_W-1:0]     chr_eff [CHR_SLOTS];
    out_item_t            answers_due [$];
    int                   mismatches;
    int                   lookups;
    int                   writes;
    int                   answers;

    function new();
      prg_limit = PRG_MAX_RST;
      chr_limit = CHR_MAX_RST;
      outer = OUTER_RST;
      select = '0;
      prg_swap = 1'b0;
      chr_swap = 1'b0;
      prg_raw[0] = 8'd0;
      prg_raw[1] = 8'd1;
      prg_raw[2] = {2'b00, prg_limit} - 8'd1;
      prg_raw[3] = {2'b00, prg_limit};
      for (int i = 0; i < CHR_SLOTS; i++) chr_raw[i] = CHR_W'(i);
      remap_all();
      mismatches = 0;
      lookups = 0;
      writes = 0;
      answers = 0;
    endfunction

    // A bank past the top of the ROM is folded down by the top bank number.
    function logic [PRG_W-1:0] fold_prg(logic [PRG_W-1:0] b);
      return (b > prg_limit) ? (b & prg_limit) : b;
    endfunction

    function logic [CHR_W-1:0] fold_chr(logic [CHR_W-1:0] b);
      return (b > chr_limit) ? (b & chr_limit) : b;
    endfunction

    // The upper outer bank halves the PRG window to 16 banks.
    function logic [PRG_W-1:0] prg_bank(logic [PRG_RAW_W-1:0] raw);
      logic [PRG_W-1:0] keep;
      keep = outer[5] ? 6'h0F : 6'h1F;
      return fold_prg(outer | (raw[PRG_W-1:0] & keep));
    endfunction

    function logic [CHR_W-1:0] chr_bank(logic [CHR_W-1:0] raw);
      return fold_chr({outer, 3'b000} | raw);
    endfunction

    function void remap_all();
      for (int i = 0; i < PRG_SLOTS; i++) prg_eff[i] = prg_bank(prg_raw[i]);
      for (int i = 0; i < CHR_SLOTS; i++) chr_eff[i] = chr_bank(chr_raw[i]);
    endfunction

    // A 2k load forces the even bank and puts its neighbor in the next slot.
    function void load_chr_pair(int slot, logic [CHR_W-1:0] v);
      logic [CHR_W-1:0] b;
      b = fold_chr(({outer, 3'b000} | v) & 9'h1FE);
      chr_raw[slot] = v;
      chr_raw[slot + 1] = v + 9'd1;
      chr_eff[slot] = b;
      chr_eff[slot + 1] = fold_chr(b + 9'd1);
    endfunction

    function void load_chr_single(int slot, logic [CHR_W-1:0] v);
      chr_raw[slot] = v;
      chr_eff[slot] = chr_bank(v);
    endfunction

    // A mode flip swaps CHR halves or PRG slots 0 and 2, and reloads the fixed slot.
    function void write_select(logic [DATA_W-1:0] v);
      logic [CHR_W-1:0]     t9;
      logic [PRG_RAW_W-1:0] t8;
      logic [PRG_W-1:0]     t6;
      int                   fixed;
      select = v[2:0];
      if (v[7] != chr_swap) begin
        for (int i = 0; i < CHR_HALF; i++) begin
          t9 = chr_raw[i];
          chr_raw[i] = chr_raw[i + CHR_HALF];
          chr_raw[i + CHR_HALF] = t9;
          t9 = chr_eff[i];
          chr_eff[i] = chr_eff[i + CHR_HALF];
          chr_eff[i + CHR_HALF] = t9;
        end
      end
      chr_swap = v[7];
      if (v[6] != prg_swap) begin
        fixed = v[6] ? 0 : 2;
        t8 = prg_raw[0];
        prg_raw[0] = prg_raw[2];
        prg_raw[2] = t8;
        t6 = prg_eff[0];
        prg_eff[0] = prg_eff[2];
        prg_eff[2] = t6;
        prg_raw[fixed] = {2'b00, prg_limit} - 8'd1;
        prg_eff[fixed] = prg_bank(prg_raw[fixed]);
      end
      prg_swap = v[6];
    endfunction

    function void write_bank(logic [DATA_W-1:0] v);
      logic [CHR_W-1:0] v9;
      int               c;
      int               p;
      v9 = {1'b0, v};
      c = chr_swap ? 4 : 0;
      p = prg_swap ? 2 : 0;
      case (select)
        BS_CHR_2K_LO: load_chr_pair(c, v9);
        BS_CHR_2K_HI: load_chr_pair(c | 2, v9);
        BS_CHR_1K_0:  load_chr_single(c ^ 4, v9);
        BS_CHR_1K_1:  load_chr_single((c ^ 4) | 1, v9);
        BS_CHR_1K_2:  load_chr_single((c ^ 4) | 2, v9);
        BS_CHR_1K_3:  load_chr_single((c ^ 4) | 3, v9);
        BS_PRG_SWAP: begin
          prg_raw[p] = v;
          prg_eff[p] = prg_bank(v);
        end
        default: begin
          prg_raw[1] = v;
          prg_eff[1] = prg_bank(v);
        end
      endcase
    endfunction

    // Updates the maps for one transfer in and returns the answer it owes.
    function out_item_t apply_access(in_item_t it);
      out_item_t            r;
      logic [OUTER_W-1:0]   v;
      r = '0;
      case (it.op)
        OP_WRITE: begin
          writes++;
          if (it.address[15]) begin
            if ((it.address & DECODE_MASK) == SELECT_ADDR) write_select(it.data);
            else if ((it.address & DECODE_MASK) == DATA_ADDR) write_bank(it.data);
          end else if (it.address >= OUTER_BASE) begin
            v = {it.data[1:0], 4'b0000};
            if (v != outer) begin
              outer = v;
              remap_all();
            end
          end
        end
        OP_PRG_LOOKUP: begin
          lookups++;
          r.bank = {3'b000, prg_eff[it.address[14:13]]};
          r.is_lookup = 1'b1;
        end
        OP_CHR_LOOKUP: begin
          lookups++;
          r.bank = chr_eff[it.address[12:10]];
          r.is_lookup = 1'b1;
        end
        default: writes++;
      endcase
      return r;
    endfunction

    function void note_access(in_item_t it);
      answers_due.push_back(apply_access(it));
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_PRG_MAX) prg_limit = val[PRG_W-1:0];
      else chr_limit = val;
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    task check_answer(out_item_t got);
      out_item_t want;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: bank %0d is_lookup %0b",
                                  got.bank, got.is_lookup));
        return;
      end
      want = answers_due.pop_front();
      answers++;
      if (got.bank !== want.bank)
        report_mismatch($sformatf("bank %0d, expected %0d", got.bank, want.bank));
      if (got.is_lookup !== want.is_lookup)
        report_mismatch($sformatf("is_lookup %0b, expected %0b",
                                  got.is_lookup, want.is_lookup));
    endtask

    task check_drained();
      if (answers_due.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", answers_due.size()));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bank_map_scoreboard ledger;
  bit                 steady;
  int                 hold_request;
  int                 items_offered;
  int                 settings_used;

  multicart_mmc3_bank_mapper_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout: transfers stopped moving.");
    $display("Simulation FAILED");
    $finish;
  end

  // Both channels are sampled at the edge where a transfer takes place.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ledger.note_access(in_item);
      if (out_valid && !out_stall) ledger.check_answer(out_item);
    end
  end

  // Result side: random stalls, a quiet stretch when asked, and one long hold.
  initial begin
    int pause;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        pause = hold_request;
        hold_request = 0;
      end else begin
        pause = steady ? 0 : $urandom_range(0, 5);
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic in_item_t make_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                                         logic [DATA_W-1:0] d);
    in_item_t it;
    it.op = op;
    it.address = a;
    it.data = d;
    return it;
  endfunction

  // Offers one item after a random gap and returns once it has transferred.
  task automatic offer(input in_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_offered++;
  endtask

  // Stops sending and waits until every owed result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_limit(idx, val);
  endtask

  // Every slot at reset, unused ops and ignored writes, outer and mode corners.
  task automatic run_directed();
    for (int i = 0; i < PRG_SLOTS; i++)
      offer(make_item(OP_PRG_LOOKUP, (16'(i) << 13) | ((i == 3) ? 16'h9FFF : 16'h0000),
                      8'h00));
    for (int i = 0; i < CHR_SLOTS; i++)
      offer(make_item(OP_CHR_LOOKUP, (16'(i) << 10) | ((i == 7) ? 16'hE3FF : 16'h0000),
                      8'hFF));
    offer(make_item(OP_UNUSED, 16'hFFFF, 8'hFF));
    offer(make_item(OP_WRITE, 16'h5FFF, 8'hFF));
    offer(make_item(OP_WRITE, 16'hE001, 8'hFF));
    offer(make_item(OP_WRITE, 16'hA000, 8'h00));
    // Outer bank zero, then the same value again, then the top outer bank.
    offer(make_item(OP_WRITE, OUTER_BASE, 8'h00));
    offer(make_item(OP_WRITE, 16'h7FFF, 8'hFC));
    offer(make_item(OP_WRITE, 16'h7FFF, 8'h03));
    // Both modes flip, load a 2k pair at the top, then flip back and load a PRG bank.
    offer(make_item(OP_WRITE, SELECT_ADDR, 8'hC0 | DATA_W'(BS_CHR_2K_LO)));
    offer(make_item(OP_WRITE, DATA_ADDR, 8'hFF));
    offer(make_item(OP_WRITE, SELECT_ADDR, DATA_W'(BS_PRG_SWAP)));
    offer(make_item(OP_WRITE, DATA_ADDR, 8'h00));
    offer(make_item(OP_WRITE, SELECT_ADDR | 16'h1FFE, DATA_W'(BS_PRG_MID)));
    offer(make_item(OP_WRITE, DATA_ADDR | 16'h1FFE, 8'hFF));
  endtask

  // Mostly select-then-load pairs and lookups, with some noise mixed in.
  task automatic random_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      offer(make_item($urandom_range(0, 1) ? OP_PRG_LOOKUP : OP_CHR_LOOKUP,
                      16'($urandom), 8'($urandom)));
    end else if (pick < 65) begin
      offer(make_item(OP_WRITE, SELECT_ADDR | (16'($urandom) & ~DECODE_MASK), 8'($urandom)));
      offer(make_item(OP_WRITE, DATA_ADDR | (16'($urandom) & ~DECODE_MASK), 8'($urandom)));
    end else if (pick < 72) begin
      offer(make_item(OP_WRITE, SELECT_ADDR | (16'($urandom) & ~DECODE_MASK), 8'($urandom)));
    end else if (pick < 80) begin
      offer(make_item(OP_WRITE, DATA_ADDR | (16'($urandom) & ~DECODE_MASK), 8'($urandom)));
    end else if (pick < 90) begin
      offer(make_item(OP_WRITE, OUTER_BASE | 16'($urandom_range(0, 16'h1FFF)),
                      8'($urandom)));
    end else if (pick < 95) begin
      offer(make_item(OP_WRITE, 16'($urandom), 8'($urandom)));
    end else begin
      offer(make_item(OP_UNUSED, 16'($urandom), 8'($urandom)));
    end
  endtask

  initial begin
    logic [PRG_W-1:0] prg_top;
    logic [CHR_W-1:0] chr_top;
    int               target;
    bit               held_once;
    bit               drained_once;
    ledger = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    steady = 1'b0;
    hold_request = 0;
    items_offered = 0;
    settings_used = 0;
    held_once = 1'b0;
    drained_once = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    settle();

    // Each phase runs under its own pair of bank limits, extremes first.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin prg_top = 6'd1;  chr_top = 9'd0;   end
        1: begin prg_top = 6'd63; chr_top = 9'd511; end
        2: begin prg_top = 6'd31; chr_top = 9'd255; end
        default: begin
          prg_top = 6'($urandom_range(1, 63));
          chr_top = 9'($urandom_range(0, 511));
        end
      endcase
      write_limit(CFG_PRG_MAX, {3'b000, prg_top});
      write_limit(CFG_CHR_MAX, chr_top);
      settings_used++;
      target = items_offered + ITEMS_PER_PHASE;
      while (items_offered < target) begin
        steady = phase[0] && (items_offered + ITEMS_PER_PHASE - target < 30);
        // A step may send two items, so these trigger once a count is passed.
        if (phase == 1 && !held_once &&
            items_offered + ITEMS_PER_PHASE - target >= 60) begin
          hold_request = LONG_HOLD;
          held_once = 1'b1;
        end
        if (phase == 2 && !drained_once &&
            items_offered + ITEMS_PER_PHASE - target >= 80) begin
          settle();
          drained_once = 1'b1;
        end
        random_step();
      end
      steady = 1'b0;
      settle();
    end

    repeat (10) @(posedge clk);
    ledger.check_drained();
    $display("Covered %0d transfers in: %0d lookups and %0d writes or unused ops.",
             items_offered, ledger.lookups, ledger.writes);
    $display("Checked %0d results under %0d pairs of bank limits.",
             ledger.answers, settings_used);
    if (ledger.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
